// ===== sv/char_stream_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKENIZER_UNIT_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_MACROS_SVH

// expr must never hold
`define CST_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// ante at one edge implies cons at the next
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Token codes, character constants, counter width and shared helpers.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int CNT_BITS = 16;
  localparam int QDEPTH   = 4;
  localparam int QIDX_W   = $clog2(QDEPTH);

  typedef logic [CNT_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX = '1;

  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_SEMI   = 4'd1;
  localparam logic [3:0] K_COLON  = 4'd2;
  localparam logic [3:0] K_LPAREN = 4'd3;
  localparam logic [3:0] K_RPAREN = 4'd4;
  localparam logic [3:0] K_LBRACE = 4'd5;
  localparam logic [3:0] K_RBRACE = 4'd6;
  localparam logic [3:0] K_INT    = 4'd7;
  localparam logic [3:0] K_IDENT  = 4'd8;
  localparam logic [3:0] K_RETURN = 4'd9;
  localparam logic [3:0] K_ERROR  = 4'd10;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_INT   = 2'd1;
  localparam logic [1:0] M_IDENT = 2'd2;

  localparam logic [7:0] C_NUL    = 8'h00;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_LF     = 8'h0A;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_COLON  = 8'h3A;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_UNDER  = 8'h5F;
  localparam logic [7:0] C_LBRACE = 8'h7B;
  localparam logic [7:0] C_RBRACE = 8'h7D;

  localparam int KW_LEN = 6;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] start;
    logic [15:0] len;
  } cst_token_t;

  typedef struct packed {
    cst_token_t tok0;
    cst_token_t tok1;
    logic       two;
  } cst_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cst_q_status_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_MAX) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  function automatic logic [15:0] out16(cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // letters of the keyword "return"
  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/cst_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classify each byte, update position state and queue the tokens it causes.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // char_code
  input  cst_pkg::cst_q_status_t q_stat,
  output logic                  q_push,
  output cst_pkg::cst_entry_t   q_wdata
);
  import cst_pkg::*;

  logic [1:0] mode_r, mode_nxt;
  cnt_t       line_r, line_nxt;
  cnt_t       col_r, col_nxt;
  cnt_t       pos_r, pos_nxt;
  cnt_t       lbeg_r, lbeg_nxt;
  cnt_t       llen_r, llen_nxt;
  logic       kw_r, kw_nxt;
  logic       acr_r, acr_nxt;

  logic [7:0] c;
  logic       is_dig, is_alp, done, accept;
  logic [1:0] n;
  cst_token_t tok [2];
  cst_token_t t;

  assign c         = in_tdata;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign is_dig    = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp    = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));

  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;
    lbeg_nxt = lbeg_r;
    llen_nxt = llen_r;
    kw_nxt   = kw_r;
    acr_nxt  = acr_r;
    done     = 1'b0;
    n        = 2'd0;
    tok[0]   = '0;
    tok[1]   = '0;
    t        = '0;

    if (mode_r == M_INT) begin
      if (is_dig) begin
        llen_nxt = sat_inc(llen_r);
        col_nxt  = sat_inc(col_r);
        pos_nxt  = sat_inc(pos_r);
        done     = 1'b1;
      end else begin
        t.kind  = K_INT;
        t.line  = out16(line_r);
        t.col   = out16(col_r);
        t.start = out16(lbeg_r);
        t.len   = out16(llen_r);
        tok[0]  = t;
        n       = 2'd1;
        mode_nxt = M_IDLE;
      end
    end else if (mode_r == M_IDENT) begin
      if (is_alp || is_dig || (c == C_UNDER)) begin
        kw_nxt   = kw_r && (llen_r < cnt_t'(KW_LEN)) && (c == kw_char(llen_r[2:0]));
        llen_nxt = sat_inc(llen_r);
        col_nxt  = sat_inc(col_r);
        pos_nxt  = sat_inc(pos_r);
        done     = 1'b1;
      end else begin
        t.kind  = (kw_r && (llen_r == cnt_t'(KW_LEN))) ? K_RETURN : K_IDENT;
        t.line  = out16(line_r);
        t.col   = out16(col_r);
        t.start = out16(lbeg_r);
        t.len   = out16(llen_r);
        tok[0]  = t;
        n       = 2'd1;
        mode_nxt = M_IDLE;
      end
    end else begin
      mode_nxt = M_IDLE;
    end

    if (!done) begin
      t = '0;
      if (acr_r && (c == C_LF)) begin
        acr_nxt = 1'b0;
        pos_nxt = sat_inc(pos_r);
      end else begin
        acr_nxt = 1'b0;
        unique case (c)
          C_NUL: begin
            t.kind = K_EOF;
            t.line = out16(line_r);
            t.col  = out16(col_r);
            tok[n[0]] = t;
            n        = n + 2'd1;
            mode_nxt = M_IDLE;
            line_nxt = cnt_t'(1);
            col_nxt  = cnt_t'(1);
            pos_nxt  = '0;
            lbeg_nxt = '0;
            llen_nxt = '0;
            kw_nxt   = 1'b0;
          end
          C_SPACE, C_TAB: begin
            col_nxt = sat_inc(col_r);
            pos_nxt = sat_inc(pos_r);
          end
          C_LF, C_CR: begin
            line_nxt = sat_inc(line_r);
            col_nxt  = cnt_t'(1);
            pos_nxt  = sat_inc(pos_r);
            acr_nxt  = (c == C_CR);
          end
          default: begin
            col_nxt = sat_inc(col_r);
            pos_nxt = sat_inc(pos_r);
            if (is_dig) begin
              mode_nxt = M_INT;
              lbeg_nxt = pos_r;
              llen_nxt = cnt_t'(1);
              kw_nxt   = 1'b0;
            end else if (is_alp || (c == C_UNDER)) begin
              mode_nxt = M_IDENT;
              lbeg_nxt = pos_r;
              llen_nxt = cnt_t'(1);
              kw_nxt   = (c == kw_char(3'd0));
            end else begin
              unique case (c)
                C_SEMI:   t.kind = K_SEMI;
                C_COLON:  t.kind = K_COLON;
                C_LPAREN: t.kind = K_LPAREN;
                C_RPAREN: t.kind = K_RPAREN;
                C_LBRACE: t.kind = K_LBRACE;
                C_RBRACE: t.kind = K_RBRACE;
                default:  t.kind = K_ERROR;
              endcase
              t.line = out16(line_nxt);
              t.col  = out16(col_nxt);
              tok[n[0]] = t;
              n = n + 2'd1;
            end
          end
        endcase
      end
    end
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_wdata.tok0  = tok[0];
  assign q_wdata.tok1  = tok[1];
  assign q_wdata.two   = n[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= cnt_t'(1);
      col_r  <= cnt_t'(1);
      pos_r  <= '0;
      lbeg_r <= '0;
      llen_r <= '0;
      kw_r   <= 1'b0;
      acr_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      pos_r  <= pos_nxt;
      lbeg_r <= lbeg_nxt;
      llen_r <= llen_nxt;
      kw_r   <= kw_nxt;
      acr_r  <= acr_nxt;
    end
  end

endmodule

// ===== sv/cst_queue.sv =====
// ----------------------------------------------------------------------------
// Tokenizer queue
// Small FIFO of token entries between the front and back ends.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cst_pkg::cst_entry_t    wdata,
  input  logic                   pop,
  output cst_pkg::cst_entry_t    head,
  output cst_pkg::cst_q_status_t stat
);
  import cst_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  cst_entry_t        mem_r [QDEPTH];
  logic [QIDX_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rptr_r];

  function automatic logic [QIDX_W-1:0] wrap_inc(logic [QIDX_W-1:0] p);
    return (p == QIDX_W'(QDEPTH - 1)) ? '0 : QIDX_W'(p + QIDX_W'(1));
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wrap_inc(wptr_r);
      if (do_pop)  rptr_r <= wrap_inc(rptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/cst_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Split queued entries into token beats and hold them in the output register.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cst_pkg::cst_q_status_t q_stat,
  input  cst_pkg::cst_entry_t    q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [71:0]            out_tdata,  // token_kind, token_line, token_col,
                                             // lexeme_start, lexeme_length
  output logic                   out_tlast   // last_of_run
);
  import cst_pkg::*;

  logic       valid_r, last_r, sel_r;
  cst_token_t tok_r;
  logic       load, take, split;

  assign load  = !valid_r || out_tready;
  assign take  = load && !q_stat.empty;
  assign split = q_head.two && !sel_r;
  assign q_pop = take && !split;

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r  <= sel_r ? q_head.tok1 : q_head.tok0;
      last_r <= !split;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (load) begin
      valid_r <= take;
      if (take) sel_r <= split;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'b0, tok_r.len, tok_r.start, tok_r.col, tok_r.line, tok_r.kind};

endmodule

// ===== sv/char_stream_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// Character stream tokenizer
// Streaming lexer: one source byte per beat in, one token per beat out.
// ----------------------------------------------------------------------------
// The block accepts one source byte per clock cycle while its four-entry token
// queue has room; the front end classifies the byte and updates line, column
// and position in that same cycle. The output port carries one token per
// cycle while out_tready is high, so a byte that both closes a literal and
// yields its own token sends two tokens out one after the other, and a long
// run of such bytes is paced by the output port once the queue has filled. A
// token passes through the queue and the output register on its way out. Byte 0
// ends the source and resets line, column and position to 1, 1 and 0.
module char_stream_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // token_kind, token_line, token_col,
                                   // lexeme_start, lexeme_length
  output logic        out_tlast    // last_of_run
);
  import cst_pkg::*;

  `include "char_stream_tokenizer_unit_macros.svh"

  cst_q_status_t q_stat;
  cst_entry_t    q_wdata, q_head;
  logic          q_push, q_pop;

  cst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  cst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  cst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `CST_ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && q_stat.full, "queue overflow")
  `CST_ASSERT_NEVER(a_no_underflow, clk, rst_n, q_pop && q_stat.empty, "queue underflow")
  `CST_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "second token missing")

endmodule
